@@ rtl/csdw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdw_pkg: shared types and constants
// Character codes, window limit and the command passed from front to back.
// ----------------------------------------------------------------------------
package csdw_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_POINT = 8'd46;

  localparam logic REG_FIRST_DIGIT   = 1'b0;
  localparam logic REG_WINDOW_DIGITS = 1'b1;

  // one entry of the front-to-back queue
  typedef struct packed {
    logic       clear;   // blank every window digit first
    logic       write;   // then write the character
    logic [5:0] pos;
    logic [7:0] glyph;
    logic       pt;
  } cmd_t;

  function automatic logic [5:0] eff_window(input logic [5:0] wd, input logic [5:0] maxd);
    eff_window = (wd > maxd) ? maxd : wd;
  endfunction

endpackage
`default_nettype wire

@@ rtl/csdw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdw_front: character classifier
// Tracks position, previous glyph and pending clear; turns each printable
// item into at most one command (clear, write or both) for the back end.
// ----------------------------------------------------------------------------
module csdw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [7:0]        in_char_code,
  input  wire logic [5:0]        win,
  input  wire logic              q_full,
  output      logic              q_push,
  output      csdw_pkg::cmd_t    q_cmd
);

  logic [7:0] position_r,  position_nxt;
  logic [7:0] prev_glyph_r, prev_glyph_nxt;
  logic       prev_pt_r,   prev_pt_nxt;
  logic       clear_pend_r, clear_pend_nxt;

  logic       accept, is_nl, printable, is_point, merge, write;
  logic [7:0] pos_base, prev_g, pos_eff, glyph;
  logic       prev_p;

  assign accept    = push && !q_full;
  assign is_nl     = (in_char_code == csdw_pkg::CH_NL) || (in_char_code == csdw_pkg::CH_CR);
  assign printable = (in_char_code >= csdw_pkg::CH_SPACE);
  assign is_point  = (in_char_code == csdw_pkg::CH_POINT);

  // a pending clear forgets position and the previous character
  assign pos_base = clear_pend_r ? 8'd0 : position_r;
  assign prev_g   = clear_pend_r ? 8'd0 : prev_glyph_r;
  assign prev_p   = clear_pend_r ? 1'b0 : prev_pt_r;

  assign merge   = is_point && !prev_p && (prev_g != 8'd0) && (pos_base != 8'd0);
  assign pos_eff = merge ? (pos_base - 8'd1) : pos_base;
  assign glyph   = is_point ? (merge ? prev_g : csdw_pkg::CH_SPACE) : in_char_code;
  assign write   = (pos_eff < {2'b00, win});

  always_comb begin
    q_cmd.clear = clear_pend_r && (win != 6'd0);
    q_cmd.write = write;
    q_cmd.pos   = pos_eff[5:0];
    q_cmd.glyph = glyph;
    q_cmd.pt    = is_point;
  end

  assign q_push = accept && printable && (q_cmd.clear || write);

  always_comb begin
    position_nxt   = position_r;
    prev_glyph_nxt = prev_glyph_r;
    prev_pt_nxt    = prev_pt_r;
    clear_pend_nxt = clear_pend_r;
    if (accept) begin
      if (is_nl) begin
        clear_pend_nxt = 1'b1;
      end else if (printable) begin
        clear_pend_nxt = 1'b0;
        prev_glyph_nxt = glyph;
        prev_pt_nxt    = is_point;
        position_nxt   = (pos_eff == 8'd255) ? 8'd255 : pos_eff + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      prev_glyph_r <= '0;
      prev_pt_r    <= 1'b0;
      clear_pend_r <= 1'b0;
    end else begin
      position_r   <= position_nxt;
      prev_glyph_r <= prev_glyph_nxt;
      prev_pt_r    <= prev_pt_nxt;
      clear_pend_r <= clear_pend_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/csdw_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdw_queue: command queue
// Short FIFO of write commands between front and back.
// ----------------------------------------------------------------------------
module csdw_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire csdw_pkg::cmd_t  wr_cmd,
  output      logic            full,
  input  wire logic            rd_en,
  output      logic            rd_valid,
  output      csdw_pkg::cmd_t  rd_cmd
);

  localparam int                    DEPTH = csdw_pkg::QDEPTH;
  localparam int                    PW    = csdw_pkg::QPTR_W;
  localparam int                    CW    = csdw_pkg::QCNT_W;
  localparam logic [PW-1:0]         PTR_LAST = PW'(DEPTH - 1);

  csdw_pkg::cmd_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            do_wr, do_rd;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    if (do_wr && !do_rd) count_nxt = count_r + CW'(1);
    else if (do_rd && !do_wr) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not follow a write");

endmodule
`default_nettype wire

@@ rtl/csdw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdw_back: digit write sequencer
// Runs one command: a window blanking sweep and/or the character, in order.
// Results sit in an output register until popped.
// ----------------------------------------------------------------------------
module csdw_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [4:0]      first_digit,
  input  wire logic [5:0]      win,
  input  wire logic            q_valid,
  input  wire csdw_pkg::cmd_t  q_cmd,
  output      logic            q_pop,
  output      logic            empty,
  input  wire logic            pop,
  output      logic [5:0]      out_digit_index,
  output      logic [7:0]      out_glyph,
  output      logic            out_point,
  output      logic            out_last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_CHAR  = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  csdw_pkg::cmd_t  cmd_r, cmd_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic [5:0]      oidx_r, oidx_nxt;
  logic [7:0]      oglyph_r, oglyph_nxt;
  logic            opt_r, opt_nxt;
  logic            olast_r, olast_nxt;
  logic            slot_free, sweep_end;

  assign slot_free = !ovalid_r || pop;
  assign sweep_end = (cnt_r == win - 6'd1);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !pop;
    oidx_nxt   = oidx_r;
    oglyph_nxt = oglyph_r;
    opt_nxt    = opt_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          cnt_nxt   = '0;
          state_nxt = q_cmd.clear ? ST_CLEAR : ST_CHAR;
        end
      end
      ST_CLEAR: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          oidx_nxt   = 6'({1'b0, first_digit} + cnt_r);
          oglyph_nxt = csdw_pkg::CH_SPACE;
          opt_nxt    = 1'b0;
          olast_nxt  = sweep_end && !cmd_r.write;
          cnt_nxt    = cnt_r + 6'd1;
          if (sweep_end) state_nxt = cmd_r.write ? ST_CHAR : ST_IDLE;
        end
      end
      ST_CHAR: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          oidx_nxt   = 6'({1'b0, first_digit} + cmd_r.pos);
          oglyph_nxt = cmd_r.glyph;
          opt_nxt    = cmd_r.pt;
          olast_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    cnt_r    <= cnt_nxt;
    oidx_r   <= oidx_nxt;
    oglyph_r <= oglyph_nxt;
    opt_r    <= opt_nxt;
    olast_r  <= olast_nxt;
  end

  assign empty           = !ovalid_r;
  assign out_digit_index = oidx_r;
  assign out_glyph       = oglyph_r;
  assign out_point       = opt_r;
  assign out_last        = olast_r;

  a_sweep_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (cnt_r < win))
    else $error("blanking sweep past window");

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != ST_IDLE))
    else $error("command taken but sequencer idle");

  a_char_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHAR && slot_free) |=> (ovalid_r && olast_r))
    else $error("character write not marked last");

endmodule
`default_nettype wire

@@ rtl/char_stream_to_digit_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_stream_to_digit_writer: character stream to display digit writes
// Front classifier, command queue and write sequencer for a display window.
// ----------------------------------------------------------------------------
// A printable item passes through the queue, the sequencer's command
//   register and the output register before its first write is shown.
// The sequencer takes a new command only when idle; a clear puts one blank
//   per window digit before the character, each waiting for a free output.
// The command queue (2 entries) lets the front take items during a sweep.
// Reset (rst_n low, synchronous): queue and output empty, position and
//   previous character zero, no clear pending, first_digit 0, window 8.
module char_stream_to_digit_writer #(
  parameter int MAX_DIGITS = csdw_pkg::MAX_DIGITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  in_char_code,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [5:0]  out_digit_index,
  output      logic [7:0]  out_glyph,
  output      logic        out_point,
  output      logic        out_last,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_wdata
);

  logic [4:0]      first_digit_r;
  logic [5:0]      window_digits_r;
  logic [5:0]      win;
  logic            q_push, q_full, q_pop, q_valid;
  csdw_pkg::cmd_t  q_wr_cmd, q_rd_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_digit_r   <= 5'd0;
      window_digits_r <= 6'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        csdw_pkg::REG_FIRST_DIGIT:   first_digit_r   <= cfg_wdata[4:0];
        csdw_pkg::REG_WINDOW_DIGITS: window_digits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign win  = csdw_pkg::eff_window(window_digits_r, 6'(MAX_DIGITS));
  assign full = q_full;

  csdw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_char_code (in_char_code),
    .win          (win),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_wr_cmd)
  );

  csdw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_cmd   (q_wr_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd_cmd)
  );

  csdw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .first_digit     (first_digit_r),
    .win             (win),
    .q_valid         (q_valid),
    .q_cmd           (q_rd_cmd),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_digit_index (out_digit_index),
    .out_glyph       (out_glyph),
    .out_point       (out_point),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

@@ bench/char_stream_to_digit_writer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_stream_to_digit_writer_tb: self-checking bench for the digit writer
// Feeds character items through the push/full side, and predicts every digit
// write in a scoreboard class. Each write popped from the block is checked
// field by field. The window is reprogrammed between phases while the block
// is idle, and sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module char_stream_to_digit_writer_tb;

  localparam int WATCHDOG_CYCLES = 400000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASE_ITEMS     = 14;
  localparam int LONG_LINE_CHARS = 270;
  localparam int CEIL_CHARS      = 256;

  typedef struct {
    logic [5:0] digit_index;
    logic [7:0] glyph;
    logic       point;
    logic       last;
  } digit_write_t;

  // Predicts the digit writes of each character and holds them until popped.
  class digit_write_tracker;
    logic [4:0]   first_digit;
    logic [5:0]   window_digits;
    logic [7:0]   position;
    logic [7:0]   prev_glyph;
    logic         prev_point;
    logic         clear_pending;
    digit_write_t writes[$];
    int           errors;
    int           checked;

    function new();
      first_digit   = 5'd0;
      window_digits = 6'd8;
      position      = 8'd0;
      prev_glyph    = 8'd0;
      prev_point    = 1'b0;
      clear_pending = 1'b0;
      errors        = 0;
      checked       = 0;
    endfunction

    function void set_reg(logic idx, logic [5:0] value);
      if (idx == csdw_pkg::REG_FIRST_DIGIT) first_digit = value[4:0];
      else window_digits = value;
    endfunction

    function void add_write(int unsigned pos, logic [7:0] glyph, logic pt);
      digit_write_t e;
      int unsigned  sum;
      sum           = first_digit + pos;
      e.digit_index = sum[5:0];
      e.glyph       = glyph;
      e.point       = pt;
      e.last        = 1'b0;
      writes.push_back(e);
    endfunction

    function void note_char(logic [7:0] c);
      int unsigned w;
      int unsigned pos;
      logic [7:0]  glyph;
      logic        pt;
      int          n_before;
      w = (window_digits > csdw_pkg::MAX_DIGITS) ? csdw_pkg::MAX_DIGITS : window_digits;
      if (c == csdw_pkg::CH_NL || c == csdw_pkg::CH_CR) begin
        clear_pending = 1'b1;
        return;
      end
      if (c < csdw_pkg::CH_SPACE) return;
      n_before = writes.size();
      if (clear_pending) begin
        for (int unsigned x = 0; x < w; x++) add_write(x, csdw_pkg::CH_SPACE, 1'b0);
        clear_pending = 1'b0;
        position      = 8'd0;
        prev_glyph    = 8'd0;
        prev_point    = 1'b0;
      end
      pos   = position;
      glyph = c;
      pt    = 1'b0;
      if (c == csdw_pkg::CH_POINT) begin
        pt = 1'b1;
        // point folds into the digit before it unless that one is lit already
        if (!prev_point && prev_glyph != 8'd0 && pos > 0) begin
          glyph = prev_glyph;
          pos   = pos - 1;
        end else begin
          glyph = csdw_pkg::CH_SPACE;
        end
      end
      if (pos < w) add_write(pos, glyph, pt);
      prev_glyph = glyph;
      prev_point = pt;
      position   = (pos < 255) ? 8'(pos + 1) : 8'd255;
      if (writes.size() > n_before) writes[$].last = 1'b1;
    endfunction

    function void check_write(logic [5:0] idx, logic [7:0] glyph, logic pt, logic lst);
      digit_write_t e;
      if (writes.size() == 0) begin
        $display("%0t: unexpected write idx=%0d glyph=%0d point=%0b last=%0b",
                 $time, idx, glyph, pt, lst);
        errors++;
        return;
      end
      e = writes.pop_front();
      checked++;
      if (idx !== e.digit_index) begin
        $display("%0t: digit_index expected %0d actual %0d", $time, e.digit_index, idx);
        errors++;
      end
      if (glyph !== e.glyph) begin
        $display("%0t: glyph expected %0d actual %0d", $time, e.glyph, glyph);
        errors++;
      end
      if (pt !== e.point) begin
        $display("%0t: point expected %0b actual %0b", $time, e.point, pt);
        errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return writes.size();
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       push         = 1'b0;
  logic       full;
  logic [7:0] in_char_code = 8'd0;
  logic       empty;
  logic       pop          = 1'b0;
  logic [5:0] out_digit_index;
  logic [7:0] out_glyph;
  logic       out_point;
  logic       out_last;
  logic       cfg_we       = 1'b0;
  logic       cfg_index    = csdw_pkg::REG_FIRST_DIGIT;
  logic [5:0] cfg_wdata    = 6'd0;

  digit_write_tracker model;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int phases_run     = 0;
  int cycles         = 0;

  char_stream_to_digit_writer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_char_code    (in_char_code),
    .empty           (empty),
    .pop             (pop),
    .out_digit_index (out_digit_index),
    .out_glyph       (out_glyph),
    .out_point       (out_point),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > WATCHDOG_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check what is popped, then decide whether to stall
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      model.check_write(out_digit_index, out_glyph, out_point, out_last);
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    push         <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    model.note_char(c);
    items_sent++;
  endtask

  // both registers, back to back, with the enable held across them
  task automatic write_window_regs(input logic [5:0] fd, input logic [5:0] wd);
    cfg_we    <= 1'b1;
    cfg_index <= csdw_pkg::REG_FIRST_DIGIT;
    cfg_wdata <= fd;
    @(posedge clk);
    model.set_reg(csdw_pkg::REG_FIRST_DIGIT, fd);
    cfg_index <= csdw_pkg::REG_WINDOW_DIGITS;
    cfg_wdata <= wd;
    @(posedge clk);
    model.set_reg(csdw_pkg::REG_WINDOW_DIGITS, wd);
    cfg_we <= 1'b0;
  endtask

  // drain: all writes back, then room for items that cause no write
  task automatic wait_idle();
    push <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  function automatic logic [7:0] rand_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return csdw_pkg::CH_NL;
    if (roll < 12) return csdw_pkg::CH_CR;
    if (roll < 22) return csdw_pkg::CH_POINT;
    if (roll < 30) return 8'($urandom_range(255));
    return 8'($urandom_range(126, 33));
  endfunction

  logic [7:0] directed_chars[25] = '{
    8'd0, 8'd31, 8'd7,                               // control codes, ignored
    csdw_pkg::CH_POINT,                              // point with nothing before it
    "A", csdw_pkg::CH_POINT, csdw_pkg::CH_POINT,     // merge, then a lone point
    8'd255, 8'd127, csdw_pkg::CH_SPACE,
    csdw_pkg::CH_CR, csdw_pkg::CH_POINT,             // point right after a clear
    "B", csdw_pkg::CH_NL, csdw_pkg::CH_NL,
    "x", "1", "2", "3", "4", "5", "6", "7", "8",
    csdw_pkg::CH_POINT                               // merges off the window edge
  };

  logic [5:0] fd_tab[6];
  logic [5:0] wd_tab[6];

  initial begin
    model = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_chars[i]) send_char(directed_chars[i]);
    wait_idle();
    phases_run++;

    fd_tab = '{6'd0, 6'd31, 6'd5, 6'd17, 6'd31, 6'($urandom_range(63))};
    wd_tab = '{6'd8, 6'd32, 6'd0, 6'd63, 6'd1, 6'd33};
    for (int p = 0; p < 6; p++) begin
      set_idle_mode(p % 4);
      write_window_regs(fd_tab[p], wd_tab[p]);
      send_char(csdw_pkg::CH_NL);
      for (int n = 0; n < PHASE_ITEMS; n++) send_char(rand_char());
      wait_idle();
      phases_run++;
    end

    // one long line so the position counter runs into its ceiling;
    // extra points are mixed in only once it is there
    set_idle_mode(0);
    write_window_regs(6'($urandom_range(63)), 6'($urandom_range(8, 1)));
    send_char(csdw_pkg::CH_NL);
    for (int n = 0; n < LONG_LINE_CHARS; n++)
      send_char((n >= CEIL_CHARS && $urandom_range(99) < 30) ?
                csdw_pkg::CH_POINT : 8'($urandom_range(255, 32)));
    send_char(csdw_pkg::CH_CR);
    send_char("Z");
    send_char(csdw_pkg::CH_POINT);
    wait_idle();
    phases_run++;

    $display("Covered %0d characters over %0d window settings and four idle patterns.",
             items_sent, phases_run);
    $display("Checked %0d digit writes, %0d mismatches.", model.checked, model.errors);
    if (model.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/csdw_pkg.sv
rtl/csdw_front.sv
rtl/csdw_queue.sv
rtl/csdw_back.sv
rtl/char_stream_to_digit_writer.sv
bench/char_stream_to_digit_writer_tb.sv
